[hw/rtl/eq_pkg.sv]
// Shared types, constants and helpers for the Euler-to-quaternion block.
`timescale 1ns / 1ps
package eq_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int ATAN_ENTRIES = 20;
    localparam int N_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int OUTQ_DEPTH = 32;
    localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [20:0] QUAT_LIMIT = 21'sd16384;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef logic signed [33:0] t_cval;
    typedef logic signed [16:0] t_trig_v;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    typedef struct packed {
        logic signed [16:0] c;
        logic signed [16:0] s;
    } t_cs;

    typedef struct packed {
        t_cs roll;
        t_cs pitch;
        t_cs yaw;
    } t_trig;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    // arctan(2^-i) in Q30, truncated
    function automatic t_cval atan_q30(input int i);
        case (i)
            0:  atan_q30 = 34'sh03243F6A8;
            1:  atan_q30 = 34'sh01DAC6705;
            2:  atan_q30 = 34'sh00FADBAFC;
            3:  atan_q30 = 34'sh007F56EA6;
            4:  atan_q30 = 34'sh003FEAB76;
            5:  atan_q30 = 34'sh001FFD55B;
            6:  atan_q30 = 34'sh000FFFAAA;
            7:  atan_q30 = 34'sh0007FFF55;
            8:  atan_q30 = 34'sh0003FFFEA;
            9:  atan_q30 = 34'sh0001FFFFD;
            10: atan_q30 = 34'sh0000FFFFF;
            11: atan_q30 = 34'sh00007FFFF;
            12: atan_q30 = 34'sh00003FFFF;
            13: atan_q30 = 34'sh00001FFFF;
            14: atan_q30 = 34'sh00000FFFF;
            15: atan_q30 = 34'sh000007FFF;
            16: atan_q30 = 34'sh000003FFF;
            17: atan_q30 = 34'sh000001FFF;
            18: atan_q30 = 34'sh000000FFF;
            19: atan_q30 = 34'sh0000007FF;
            default: atan_q30 = '0;
        endcase
    endfunction

    function automatic logic signed [15:0] clamp_angle(input logic signed [15:0] a);
        if (a > ANGLE_LIMIT) begin
            clamp_angle = ANGLE_LIMIT;
        end else if (a < -ANGLE_LIMIT) begin
            clamp_angle = -ANGLE_LIMIT;
        end else begin
            clamp_angle = a;
        end
    endfunction

endpackage

[hw/rtl/eq_front.sv]
// Input request queue: holds two requests and issues them when the back end has credit.
`timescale 1ns / 1ps
module eq_front
    import eq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_full,
    input  t_angles i_angles,
    input  logic    i_credit_ok,
    output logic    o_issue,
    output t_angles o_angles
);

    t_angles    r_buf [0:1];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push_ok;

    assign o_full    = (r_cnt == 2'd2);
    assign w_push_ok = i_push && !o_full;
    assign o_issue   = (r_cnt != 2'd0) && i_credit_ok;
    // clamp on the way out so the half angle stays in CORDIC range
    assign o_angles.roll  = clamp_angle(r_buf[r_rp].roll);
    assign o_angles.pitch = clamp_angle(r_buf[r_rp].pitch);
    assign o_angles.yaw   = clamp_angle(r_buf[r_rp].yaw);

    always_comb begin
        n_wp  = r_wp ^ w_push_ok;
        n_rp  = r_rp ^ o_issue;
        n_cnt = r_cnt + {1'b0, w_push_ok} - {1'b0, o_issue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_buf[r_wp] <= i_angles;
        end
    end

endmodule

[hw/rtl/eq_cordic.sv]
// Pipelined rotation-mode CORDIC: cosine and sine of the three half angles.
`timescale 1ns / 1ps
module eq_cordic
    import eq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_angles i_angles,
    output logic    o_valid,
    output t_trig   o_trig
);

    t_cval         r_x [0:2][0:N_STEPS];
    t_cval         r_y [0:2][0:N_STEPS];
    t_cval         r_z [0:2][0:N_STEPS];
    logic          r_v [0:N_STEPS];
    logic          r_ov;
    t_trig_v       r_c [0:2];
    t_trig_v       r_s [0:2];
    logic signed [15:0] w_ang [0:2];

    assign w_ang[0] = i_angles.roll;
    assign w_ang[1] = i_angles.pitch;
    assign w_ang[2] = i_angles.yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar k = 0; k < N_STEPS; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        // half angle in Q30 is the Q2.13 angle times 2^16
        always_ff @(posedge i_clk) begin
            r_x[l][0] <= CORDIC_GAIN;
            r_y[l][0] <= '0;
            r_z[l][0] <= {{2{w_ang[l][15]}}, w_ang[l], 16'd0};
        end
        for (genvar i = 0; i < N_STEPS; i++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (!r_z[l][i][33]) begin
                    r_x[l][i+1] <= r_x[l][i] - (r_y[l][i] >>> i);
                    r_y[l][i+1] <= r_y[l][i] + (r_x[l][i] >>> i);
                    r_z[l][i+1] <= r_z[l][i] - atan_q30(i);
                end else begin
                    r_x[l][i+1] <= r_x[l][i] + (r_y[l][i] >>> i);
                    r_y[l][i+1] <= r_y[l][i] - (r_x[l][i] >>> i);
                    r_z[l][i+1] <= r_z[l][i] + atan_q30(i);
                end
            end
        end
        // round to Q15
        always_ff @(posedge i_clk) begin
            r_c[l] <= 17'((r_x[l][N_STEPS] + 34'sd16384) >>> 15);
            r_s[l] <= 17'((r_y[l][N_STEPS] + 34'sd16384) >>> 15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[N_STEPS];
        end
    end

    assign o_valid      = r_ov;
    assign o_trig.roll  = '{c: r_c[0], s: r_s[0]};
    assign o_trig.pitch = '{c: r_c[1], s: r_s[1]};
    assign o_trig.yaw   = '{c: r_c[2], s: r_s[2]};

endmodule

[hw/rtl/eq_combine.sv]
// Triple products, sums, rounding and saturation into the four quaternion parts.
`timescale 1ns / 1ps
module eq_combine
    import eq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_trig i_trig,
    output logic  o_valid,
    output t_quat o_quat
);

    logic [2:0]         r_v;
    logic signed [33:0] r_cc, r_ss, r_sc, r_cs;
    t_trig_v            r_cr, r_sr;
    logic signed [50:0] r_ccc, r_sss, r_ccs, r_ssc, r_scs, r_csc, r_scc, r_css;
    t_quat              r_q;

    function automatic logic signed [15:0] finish(input logic signed [51:0] s);
        logic signed [51:0] t;
        logic signed [20:0] q;
        t = (s + 52'sd1073741824) >>> 31;
        q = t[20:0];
        if (q > QUAT_LIMIT) begin
            finish = 16'(QUAT_LIMIT);
        end else if (q < -QUAT_LIMIT) begin
            finish = 16'(-QUAT_LIMIT);
        end else begin
            finish = q[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cc <= i_trig.yaw.c * i_trig.pitch.c;
        r_ss <= i_trig.yaw.s * i_trig.pitch.s;
        r_sc <= i_trig.yaw.s * i_trig.pitch.c;
        r_cs <= i_trig.yaw.c * i_trig.pitch.s;
        r_cr <= i_trig.roll.c;
        r_sr <= i_trig.roll.s;

        r_ccc <= r_cc * r_cr;
        r_sss <= r_ss * r_sr;
        r_ccs <= r_cc * r_sr;
        r_ssc <= r_ss * r_cr;
        r_scs <= r_sc * r_sr;
        r_csc <= r_cs * r_cr;
        r_scc <= r_sc * r_cr;
        r_css <= r_cs * r_sr;

        r_q.w <= finish(52'(r_ccc) + 52'(r_sss));
        r_q.x <= finish(52'(r_ccs) - 52'(r_ssc));
        r_q.y <= finish(52'(r_scs) + 52'(r_csc));
        r_q.z <= finish(52'(r_scc) - 52'(r_css));
    end

    assign o_valid = r_v[2];
    assign o_quat  = r_q;

endmodule

[hw/rtl/eq_outq.sv]
// Result queue: holds finished quaternions until they are popped.
`timescale 1ns / 1ps
module eq_outq
    import eq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  t_quat              i_quat,
    input  logic               i_pop,
    output logic               o_empty,
    output t_quat              o_quat,
    output logic [OUTQ_AW:0]   o_count
);

    t_quat              r_mem [0:OUTQ_DEPTH-1];
    logic [OUTQ_AW-1:0] r_wp, r_rp;
    logic [OUTQ_AW:0]   r_cnt, n_cnt;
    logic               w_rd;

    assign o_empty = (r_cnt == '0);
    assign w_rd    = i_pop && !o_empty;
    assign o_quat  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt + {{OUTQ_AW{1'b0}}, i_wr} - {{OUTQ_AW{1'b0}}, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OUTQ_AW'(i_wr);
            r_rp  <= r_rp + OUTQ_AW'(w_rd);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_quat;
        end
    end

endmodule

[hw/rtl/euler_to_quaternion.sv]
// Top level: Z-Y-X Euler angles to unit quaternion, queue interface on both sides.
`timescale 1ns / 1ps
// Takes roll, pitch and yaw in signed Q2.13 radians (saturated to plus or
// minus pi) and gives the unit quaternion w, x, y, z in signed Q1.14 for the
// yaw-pitch-roll rotation order. Both sides look like a queue: push a request
// while full is low, pop a result while empty is low. One request is taken
// every cycle while full is low and one result leaves every cycle while
// pop is high and empty is low. A request passes in order through the
// front queue register, the CORDIC load stage, the unrolled CORDIC steps,
// the Q15 rounding stage, the two multiply stages, the saturation stage
// and the result queue write before it can be popped. A two-entry front
// queue holds requests; it issues into the pipeline only while the back
// end holds a free slot in the 32-entry result queue for every request in
// flight, so the pipeline itself never stalls and a slow consumer only
// pushes back through full.
module euler_to_quaternion
    import eq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    t_angles          w_in_angles, w_issue_angles;
    logic             w_issue, w_credit_ok;
    logic             w_trig_v, w_quat_v;
    t_trig            w_trig;
    t_quat            w_quat, w_out_quat;
    logic [OUTQ_AW:0] w_outq_cnt;
    logic [OUTQ_AW:0] r_inflight, n_inflight;
    logic [OUTQ_AW+1:0] w_used;

    assign w_in_angles = '{roll: i_roll_angle, pitch: i_pitch_angle, yaw: i_yaw_angle};

    // Every request in flight owns one result queue slot.
    assign w_used      = {1'b0, r_inflight} + {1'b0, w_outq_cnt};
    assign w_credit_ok = (w_used < (OUTQ_AW+2)'(OUTQ_DEPTH));

    always_comb begin
        n_inflight = r_inflight + {{OUTQ_AW{1'b0}}, w_issue}
                                - {{OUTQ_AW{1'b0}}, w_quat_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // Hold and issue requests.
    eq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_angles    (w_in_angles),
        .i_credit_ok (w_credit_ok),
        .o_issue     (w_issue),
        .o_angles    (w_issue_angles)
    );

    // Advance through the CORDIC stages.
    eq_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_issue),
        .i_angles (w_issue_angles),
        .o_valid  (w_trig_v),
        .o_trig   (w_trig)
    );

    // Form products and saturate.
    eq_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_v),
        .i_trig  (w_trig),
        .o_valid (w_quat_v),
        .o_quat  (w_quat)
    );

    // Hold results until popped.
    eq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_quat_v),
        .i_quat  (w_quat),
        .i_pop   (pop),
        .o_empty (empty),
        .o_quat  (w_out_quat),
        .o_count (w_outq_cnt)
    );

    assign o_quat_w = w_out_quat.w;
    assign o_quat_x = w_out_quat.x;
    assign o_quat_y = w_out_quat.y;
    assign o_quat_z = w_out_quat.z;

    // Credits never overcommit the result queue.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= (OUTQ_AW+2)'(OUTQ_DEPTH))
        else $error("result queue overcommitted");

    // A finished result always finds a free slot.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_quat_v |-> (w_outq_cnt != (OUTQ_AW+1)'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // No result appears without a request in flight.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_quat_v |-> (r_inflight != '0))
        else $error("result without request");

endmodule

[bench/quat_checker.sv]
// Checker: predicts quaternion results from accepted angle requests and compares them.
`timescale 1ns / 1ps
module quat_checker
    import eq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int GAIN_Q30 = 32'h26DD3B6A;

    t_quat exp_store [int];
    int    exp_wr = 0;
    int    exp_rd = 0;

    function automatic longint half_atan(input int i);
        longint tbl[20] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};
        return tbl[i];
    endfunction

    // cosine and sine of half the Q2.13 angle, Q15
    function automatic void half_trig(input logic signed [15:0] ang, output longint c,
                                      output longint s);
        longint a, x, y, z, dx, dy;
        a = ang;
        if (a > 25736) a = 25736;
        if (a < -25736) a = -25736;
        x = GAIN_Q30;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= half_atan(i);
            end else begin
                x += dx; y -= dy; z += half_atan(i);
            end
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
    endfunction

    function automatic logic signed [15:0] round_part(input longint sum);
        longint q;
        q = (sum + (64'sd1 <<< 30)) >>> 31;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    function automatic t_quat predict_quat(input t_angles a);
        longint cr, sr, cp, sp, cy, sy;
        t_quat q;
        half_trig(a.roll, cr, sr);
        half_trig(a.pitch, cp, sp);
        half_trig(a.yaw, cy, sy);
        q.w = round_part(cy * cp * cr + sy * sp * sr);
        q.x = round_part(cy * cp * sr - sy * sp * cr);
        q.y = round_part(sy * cp * sr + cy * sp * cr);
        q.z = round_part(sy * cp * cr - cy * sp * sr);
        return q;
    endfunction

    assign o_pending = exp_wr - exp_rd;

    always @(posedge i_clk) begin
        t_quat q;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (exp_rd == exp_wr) begin
                    if (o_fail_count < 10) $display("ERROR: unexpected result");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    q = exp_store[exp_rd];
                    exp_store.delete(exp_rd);
                    exp_rd++;
                    if (q != {i_quat_w, i_quat_x, i_quat_y, i_quat_z}) begin
                        if (o_fail_count < 10)
                            $display("ERROR: exp w%0d x%0d y%0d z%0d got w%0d x%0d y%0d z%0d",
                                     q.w, q.x, q.y, q.z, i_quat_w, i_quat_x, i_quat_y,
                                     i_quat_z);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                exp_store[exp_wr] = predict_quat('{i_roll_angle, i_pitch_angle, i_yaw_angle});
                exp_wr++;
            end
        end
    end

endmodule

[bench/tb.sv]
// Testbench top: drives angle requests and result pops, reports the verdict.
`timescale 1ns / 1ps
module tb;
    import eq_pkg::*;

    localparam int LATENCY = N_STEPS + 7;
    localparam int WATCHDOG = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty;
    logic signed [15:0] roll = '0, pitch = '0, yaw = '0;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    int                 fail_count, pending;
    int                 send_idle = 24, recv_idle = 74;
    bit                 recv_hold = 1'b0;
    int                 stuck = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    euler_to_quaternion u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .empty(empty), .pop(pop),
        .o_quat_w(quat_w), .o_quat_x(quat_x), .o_quat_y(quat_y), .o_quat_z(quat_z)
    );

    quat_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .i_empty(empty), .i_pop(pop),
        .i_quat_w(quat_w), .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Pick a random angle: mostly in range, sometimes raw 16 bits to hit saturation.
    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return ($urandom_range(0, 1) ? 16'sd25736 : -16'sd25736);
            default: return 16'($signed($urandom_range(0, 51472)) - 32'sd25736);
        endcase
    endfunction

    // Offer one request, idling at the current rate, and hold until accepted.
    task automatic send_request(input logic signed [15:0] r, p, y);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        roll  <= r;
        pitch <= p;
        yaw   <= y;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering and wait until every expected result has been popped.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: pop at random unless held off.
    always @(posedge i_clk) begin
        pop <= !recv_hold && ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: count cycles with no accepted handshake.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= WATCHDOG) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Long receiver hold-off while the sender keeps pushing.
    initial begin
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin
        logic signed [15:0] corner[7];
        corner = '{16'sh8000, 16'sh7FFF, -16'sd25736, 16'sd25736, 16'sd0, 16'sd1, -16'sd1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes on each axis, saturation, and all-equal corners.
        foreach (corner[i]) send_request(corner[i], 16'sd0, 16'sd0);
        foreach (corner[i]) send_request(16'sd0, corner[i], 16'sd0);
        foreach (corner[i]) send_request(16'sd0, 16'sd0, corner[i]);
        send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_request(16'sd12868, 16'sd12868, 16'sd12868);
        send_request(-16'sd12868, -16'sd12868, -16'sd12868);

        // Random in three idle phases; pause for a full drain after the first.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle = 74;
                recv_idle = 24;
            end else if (phase == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < 230; n++) send_request(rand_angle(), rand_angle(), rand_angle());
            if (phase == 0) drain();
        end

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/eq_pkg.sv
hw/rtl/eq_front.sv
hw/rtl/eq_cordic.sv
hw/rtl/eq_combine.sv
hw/rtl/eq_outq.sv
hw/rtl/euler_to_quaternion.sv
bench/quat_checker.sv
bench/tb.sv
